// ===== design/shrg_pkg.sv =====
`timescale 1ns / 1ps
package shrg_pkg;

  localparam logic [31:0] StepInc = 32'he120fc15;
  localparam logic [31:0] MixMulA = 32'h4a39b70d;
  localparam logic [31:0] MixMulB = 32'h12fad5c9;

  localparam int DivSteps = 32;
  localparam int CntW     = $clog2(DivSteps);

  localparam logic FuncSeed = 1'b0;
  localparam logic FuncDraw = 1'b1;

  localparam logic RegWorldSeed = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_DIV,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;       // request accepted this cycle
    logic mul1;       // first mixing multiply
    logic mul2;       // fold, second multiply
    logic mix;        // final fold, set up range reduction
    logic div_step;   // one restoring remainder step
    logic load_out;   // move result into output register
  } shrg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic range_bad;  // max not above min
    logic cnt_last;   // last remainder step
    logic out_busy;   // output register holds an untaken result
  } shrg_stat_t;

  function automatic logic [31:0] mix_fold(input logic [31:0] p);
    mix_fold = p ^ {16'h0000, p[31:16]};
  endfunction

endpackage

// ===== design/shrg_ctrl.sv =====
`timescale 1ns / 1ps
module shrg_ctrl
  import shrg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_func_i,
  output logic       in_ready_o,
  input  shrg_stat_t stat_i,
  output shrg_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   take;

  assign take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && in_func_i == FuncDraw) state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MIX;
      ST_MIX: begin
        state_d = stat_i.range_bad ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.cnt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = take;
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.mix      = (state_q == ST_MIX);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_DONE) && !stat_i.out_busy;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !stat_i.out_busy)
    else $error("result loaded over an untaken result");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && stat_i.cnt_last) |=> state_q == ST_DONE)
    else $error("remainder loop did not finish");

  a_draw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_func_i == FuncDraw) |=> state_q == ST_MUL1)
    else $error("draw request did not start mixing");

  a_seed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_func_i == FuncSeed) |=> state_q == ST_IDLE)
    else $error("seed request left controller busy");

endmodule

// ===== design/shrg_dp.sv =====
`timescale 1ns / 1ps
module shrg_dp
  import shrg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  shrg_cmd_t   cmd_i,
  output shrg_stat_t  stat_o,
  input  logic        in_func_i,
  input  logic [15:0] in_pos_x_i,
  input  logic [15:0] in_pos_y_i,
  input  logic [31:0] in_range_min_i,
  input  logic [31:0] in_range_max_i,
  input  logic [31:0] world_seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_value_o,
  output logic [31:0] out_raw_o,
  output logic        out_err_o
);

  logic [31:0]     gen_q;
  logic [31:0]     lo_q, hi_q;
  logic [31:0]     prod_q;
  logic [31:0]     raw_q;
  logic [31:0]     width_q;
  logic [31:0]     rem_q, dvd_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic [31:0]     value_q, out_raw_q;
  logic            err_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_lo;
  logic [32:0] rem_sh, rem_diff;
  logic        range_bad;

  assign range_bad = !($signed(hi_q) > $signed(lo_q));

  // Only the low word of each product is kept
  assign mul_a  = cmd_i.mul1 ? gen_q : mix_fold(prod_q);
  assign mul_b  = cmd_i.mul1 ? MixMulA : MixMulB;
  assign mul_lo = mul_a * mul_b;

  assign rem_sh   = {rem_q, dvd_q[31]};
  assign rem_diff = rem_sh - {1'b0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cmd_i.take) begin
      gen_q <= (in_func_i == FuncDraw) ? gen_q + StepInc
                                       : {in_pos_x_i, in_pos_y_i} + world_seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      lo_q <= in_range_min_i;
      hi_q <= in_range_max_i;
    end
    if (cmd_i.mul1 || cmd_i.mul2) prod_q <= mul_lo;
    if (cmd_i.mix) begin
      raw_q   <= mix_fold(prod_q);
      dvd_q   <= mix_fold(prod_q);
      rem_q   <= '0;
      width_q <= hi_q - lo_q;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
    end
    if (cmd_i.load_out) begin
      out_raw_q <= raw_q;
      err_q     <= range_bad;
      value_q   <= range_bad ? lo_q : lo_q + rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mix) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.range_bad = range_bad;
  assign stat_o.cnt_last  = (cnt_q == CntW'(DivSteps - 1));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = value_q;
  assign out_raw_o   = out_raw_q;
  assign out_err_o   = err_q;

endmodule

// ===== design/seeded_hash_random_generator.sv =====
`timescale 1ns / 1ps
// Seeded hash random generator. A seed request (tuser = 0) loads the 32-bit
// generator state from {pos_x, pos_y} plus the world_seed register and
// returns nothing. A draw request (tuser = 1) advances the state,
// mixes it through two multiply/xor-fold rounds on one shared 32x32
// multiplier, and reduces the word into [range_min, range_max) with a
// restoring remainder unit that retires one bit per cycle. A draw occupies
// the block through one accept step, two multiply steps, one fold step,
// 32 remainder steps and a load of the output register; when max is not
// above min the remainder steps are skipped and the result flags
// range_error with value = range_min. A finished result sits in the output
// register, so the next request is taken while it waits; a draw that
// completes while the previous result is still untaken holds until it is
// taken. world_seed sits at byte address 0 and must be written only while
// the block is idle.
module seeded_hash_random_generator
  import shrg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16],
                                     // range_min[63:32], range_max[95:64]
  input  logic        s_axis_tuser,  // func[0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // value[31:0], raw_word[63:32]
  output logic        m_axis_tuser,  // range_error[0]
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  shrg_cmd_t   cmd;
  shrg_stat_t  stat;
  logic [31:0] world_seed_q;
  logic [31:0] value;
  logic [31:0] raw_word;

  // Register file: a single word register, index taken from paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_seed_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == RegWorldSeed) begin
      world_seed_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == RegWorldSeed) ? world_seed_q : '0;

  // Sequence the request through the datapath
  shrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold state, mix, reduce and register the result
  shrg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_func_i      (s_axis_tuser),
    .in_pos_x_i     (s_axis_tdata[15:0]),
    .in_pos_y_i     (s_axis_tdata[31:16]),
    .in_range_min_i (s_axis_tdata[63:32]),
    .in_range_max_i (s_axis_tdata[95:64]),
    .world_seed_i   (world_seed_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_value_o    (value),
    .out_raw_o      (raw_word),
    .out_err_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {raw_word, value};

endmodule
